>>> src/alnf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alnf_pkg
// Shared constants and types for the advertising local-name filter.
// ----------------------------------------------------------------------------
package alnf_pkg;

  localparam int MAX_NAME_BYTES_DEF   = 31;
  localparam int MAX_TARGET_BYTES_DEF = 16;

  localparam int BYTE_W     = 8;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int TLEN_W     = 5;
  localparam int NAME_LEN_W = 5;

  // target bytes, zero-extended so any index below 32 stays in range
  localparam int TGT_EXT_W = 256;

  localparam logic [BYTE_W-1:0] NAME_TYPE = 8'h09;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEN  = 2'd2;

  // one parsed byte, as seen by the matcher
  typedef struct packed {
    logic              push;
    logic [BYTE_W-1:0] data;
    logic              name_done;
  } step_t;

endpackage

>>> src/adv_local_name_filter_top.sv
`timescale 1ns / 1ps
// Result path: a last byte waits in the byte stage, then its result is registered.
// Throughput: one payload byte per cycle; the byte stage stalls only while a finished
//   result is held on the output and the next byte is also a last byte.
// Reset: synchronous, clears the byte stage, the result register, the parser state
//   and the target registers.
// ----------------------------------------------------------------------------
// adv_local_name_filter_top
// Finds the complete local name in an advertising payload and matches a target.
// ----------------------------------------------------------------------------
module adv_local_name_filter_top #(
  parameter int MAX_NAME_BYTES   = alnf_pkg::MAX_NAME_BYTES_DEF,
  parameter int MAX_TARGET_BYTES = alnf_pkg::MAX_TARGET_BYTES_DEF,
  localparam int CW = $clog2(MAX_NAME_BYTES + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [alnf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [alnf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [alnf_pkg::BYTE_W-1:0]     adv_byte,
  input  logic                            last_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            name_found,
  output logic [alnf_pkg::NAME_LEN_W-1:0] name_length,
  output logic                            target_match
);

  logic [alnf_pkg::CFG_DATA_W-1:0] target_low;
  logic [alnf_pkg::CFG_DATA_W-1:0] target_high;
  logic [alnf_pkg::TLEN_W-1:0]     target_len;

  logic                        byte_valid;
  logic [alnf_pkg::BYTE_W-1:0] byte_data;
  logic                        byte_last;
  logic                        advance;
  logic                        in_take;
  alnf_pkg::step_t             step;
  logic [CW-1:0]               count_next;
  logic                        match_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_low  <= '0;
      target_high <= '0;
      target_len  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        alnf_pkg::REG_TARGET_LOW:  target_low  <= cfg_data;
        alnf_pkg::REG_TARGET_HIGH: target_high <= cfg_data;
        alnf_pkg::REG_TARGET_LEN:  target_len  <= cfg_data[alnf_pkg::TLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // a last byte advances only when the result register is free or draining
  assign advance  = byte_valid && (!byte_last || !out_valid || !out_stall);
  assign in_stall = byte_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_take) begin
      byte_valid <= 1'b1;
    end else if (advance) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_data <= adv_byte;
      byte_last <= last_byte;
    end
  end

  alnf_parse #(
    .MAX_NAME_BYTES(MAX_NAME_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .clear     (byte_last),
    .data      (byte_data),
    .step      (step),
    .count_next(count_next)
  );

  alnf_match #(
    .MAX_NAME_BYTES  (MAX_NAME_BYTES),
    .MAX_TARGET_BYTES(MAX_TARGET_BYTES)
  ) u_match (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .clear      (byte_last),
    .step       (step),
    .count_next (count_next),
    .target_low (target_low),
    .target_high(target_high),
    .target_len (target_len),
    .match_next (match_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && byte_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && byte_last) begin
      name_found   <= step.name_done;
      name_length  <= alnf_pkg::NAME_LEN_W'(count_next);
      target_match <= match_next;
    end
  end

endmodule

>>> src/alnf_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alnf_parse
// Walks the length-type-value structures and controls name capture.
// ----------------------------------------------------------------------------
module alnf_parse #(
  parameter int MAX_NAME_BYTES = alnf_pkg::MAX_NAME_BYTES_DEF,
  localparam int CW = $clog2(MAX_NAME_BYTES + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      clear,
  input  logic [alnf_pkg::BYTE_W-1:0] data,
  output alnf_pkg::step_t           step,
  output logic [CW-1:0]             count_next
);

  typedef enum logic [2:0] {
    PH_LENGTH = 3'b001,
    PH_TYPE   = 3'b010,
    PH_VALUE  = 3'b100
  } phase_t;

  phase_t                      phase, phase_next;
  logic [alnf_pkg::BYTE_W-1:0] remaining, remaining_next, remaining_dec;
  logic                        capturing, capturing_next;
  logic                        name_done, name_done_next;
  logic [CW-1:0]               count;
  logic                        push;

  assign remaining_dec = remaining - 8'd1;

  always_comb begin
    phase_next     = phase;
    remaining_next = remaining;
    capturing_next = capturing;
    name_done_next = name_done;
    count_next     = count;
    push           = 1'b0;
    unique case (phase)
      PH_LENGTH: begin
        // a zero length byte is a structure of its own
        if (data != '0) begin
          remaining_next = data;
          phase_next     = PH_TYPE;
        end
      end
      PH_TYPE: begin
        remaining_next = remaining_dec;
        if (data == alnf_pkg::NAME_TYPE && !name_done) begin
          name_done_next = 1'b1;
          capturing_next = 1'b1;
        end
        if (remaining_dec == '0) begin
          capturing_next = 1'b0;
          phase_next     = PH_LENGTH;
        end else begin
          phase_next = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (capturing) begin
          if (data == '0 || count >= CW'(MAX_NAME_BYTES)) begin
            capturing_next = 1'b0;
          end else begin
            push       = 1'b1;
            count_next = count + CW'(1);
          end
        end
        remaining_next = remaining_dec;
        if (remaining_dec == '0) begin
          capturing_next = 1'b0;
          phase_next     = PH_LENGTH;
        end
      end
      default: phase_next = PH_LENGTH;
    endcase
  end

  assign step.push      = push;
  assign step.data      = data;
  assign step.name_done = name_done_next;

  always_ff @(posedge clk) begin
    if (rst || (en && clear)) begin
      phase     <= PH_LENGTH;
      remaining <= '0;
      capturing <= 1'b0;
      name_done <= 1'b0;
      count     <= '0;
    end else if (en) begin
      phase     <= phase_next;
      remaining <= remaining_next;
      capturing <= capturing_next;
      name_done <= name_done_next;
      count     <= count_next;
    end
  end

endmodule

>>> src/alnf_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alnf_match
// Window of the newest name bytes, compared with the target on every push.
// ----------------------------------------------------------------------------
module alnf_match #(
  parameter int MAX_NAME_BYTES   = alnf_pkg::MAX_NAME_BYTES_DEF,
  parameter int MAX_TARGET_BYTES = alnf_pkg::MAX_TARGET_BYTES_DEF,
  localparam int CW   = $clog2(MAX_NAME_BYTES + 1),
  localparam int TW   = $clog2(MAX_TARGET_BYTES + 1),
  localparam int IW   = (MAX_TARGET_BYTES > 1) ? $clog2(MAX_TARGET_BYTES) : 1,
  localparam int CMPW = (CW > TW) ? CW : TW
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          clear,
  input  alnf_pkg::step_t               step,
  input  logic [CW-1:0]                 count_next,
  input  logic [alnf_pkg::CFG_DATA_W-1:0] target_low,
  input  logic [alnf_pkg::CFG_DATA_W-1:0] target_high,
  input  logic [alnf_pkg::TLEN_W-1:0]   target_len,
  output logic                          match_next
);

  logic [alnf_pkg::BYTE_W-1:0]    window     [MAX_TARGET_BYTES];
  logic [alnf_pkg::BYTE_W-1:0]    window_new [MAX_TARGET_BYTES];
  logic [alnf_pkg::BYTE_W-1:0]    tgt        [MAX_TARGET_BYTES];
  logic [alnf_pkg::TGT_EXT_W-1:0] tgt_ext;
  logic [TW-1:0]                  len_sat;
  logic [IW-1:0]                  idx [MAX_TARGET_BYTES];
  logic                           match_seen;
  logic                           hit;

  assign tgt_ext = {128'd0, target_high, target_low};

  always_comb begin
    for (int k = 0; k < MAX_TARGET_BYTES; k++) begin
      tgt[k] = tgt_ext[8*k +: 8];
    end
  end

  // saturate the length to the window depth
  assign len_sat = (int'(target_len) > MAX_TARGET_BYTES) ? TW'(MAX_TARGET_BYTES)
                                                         : TW'(target_len);

  always_comb begin
    window_new[0] = step.data;
    for (int j = 1; j < MAX_TARGET_BYTES; j++) begin
      window_new[j] = window[j-1];
    end
  end

  // window_new[0] is the newest byte and lines up with the last target byte
  always_comb begin
    hit = step.push && (len_sat != '0) && (CMPW'(count_next) >= CMPW'(len_sat));
    for (int j = 0; j < MAX_TARGET_BYTES; j++) begin
      idx[j] = IW'(int'(len_sat) - 1 - j);
      if (j < int'(len_sat) && window_new[j] != tgt[idx[j]]) begin
        hit = 1'b0;
      end
    end
  end

  assign match_next = match_seen | hit;

  always_ff @(posedge clk) begin
    if (en && step.push) begin
      for (int j = 0; j < MAX_TARGET_BYTES; j++) begin
        window[j] <= window_new[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (en && clear)) begin
      match_seen <= 1'b0;
    end else if (en) begin
      match_seen <= match_next;
    end
  end

endmodule

>>> src/alnf_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alnf_check
// Port-level checks on the filter's result channel.
// ----------------------------------------------------------------------------
module alnf_check (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            name_found,
  input logic [alnf_pkg::NAME_LEN_W-1:0] name_length,
  input logic                            target_match
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(name_found) && $stable(name_length)
                               && $stable(target_match))
    else $error("stalled result changed");

  a_no_name: assert property (@(posedge clk) disable iff (rst)
    out_valid && !name_found |-> name_length == '0 && !target_match)
    else $error("name bytes reported without a name structure");

  a_match_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && target_match |-> name_found && name_length != '0)
    else $error("target match with an empty name");

endmodule

bind adv_local_name_filter_top alnf_check u_alnf_check (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .name_found  (name_found),
  .name_length (name_length),
  .target_match(target_match)
);

>>> tb/adv_local_name_filter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adv_local_name_filter_top_tb
// Streams advertising payloads into the local-name filter. A local parser
// tracks the length-type-value walk, the name capture and the target window.
// It queues one name report for every last byte. Every report the block
// gives is checked field by field against the oldest queued one. Both sides
// idle at random, and one long output hold-off fills the block.
// ----------------------------------------------------------------------------
module adv_local_name_filter_top_tb;

  localparam int IDLE_PCT       = 23;
  localparam int HOLD_CYCLES    = 120;
  localparam int SETTLE_CYCLES  = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEM_GOAL      = 1400;
  localparam int NAME_CLAMP     = alnf_pkg::MAX_NAME_BYTES_DEF;
  localparam int TGT_MAX        = alnf_pkg::MAX_TARGET_BYTES_DEF;

  typedef enum logic [2:0] {
    PH_LENGTH = 3'b001,
    PH_TYPE   = 3'b010,
    PH_VALUE  = 3'b100
  } parse_phase_t;

  typedef struct packed {
    logic                            found;
    logic [alnf_pkg::NAME_LEN_W-1:0] length;
    logic                            hit;
  } name_report_t;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            cfg_write = 1'b0;
  logic [alnf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [alnf_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  logic [alnf_pkg::BYTE_W-1:0]     adv_byte  = '0;
  logic                            last_byte = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic                            name_found;
  logic [alnf_pkg::NAME_LEN_W-1:0] name_length;
  logic                            target_match;

  // local copy of the target registers and the parser state
  logic [63:0]                     m_lo;
  logic [63:0]                     m_hi;
  logic [4:0]                      m_len;
  parse_phase_t                    m_phase;
  logic [7:0]                      m_remain;
  bit                              m_capture;
  bit                              m_done;
  logic [alnf_pkg::NAME_LEN_W-1:0] m_count;
  logic [7:0]                      m_win [TGT_MAX];
  bit                              m_hit;

  name_report_t name_reports [$];
  logic [7:0]   adv_q [$];
  int           n_sent      = 0;
  int           n_bad       = 0;
  int           idle_cycles = 0;
  bit           calm        = 1'b0;
  bit           hold_req    = 1'b0;
  bit           hold_seen   = 1'b0;
  int           hold_left   = 0;

  adv_local_name_filter_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .adv_byte     (adv_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .name_found   (name_found),
    .name_length  (name_length),
    .target_match (target_match)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] tgt_byte(int k);
    if (k < 8) return m_lo[8*k +: 8];
    return m_hi[8*(k-8) +: 8];
  endfunction

  function automatic void clear_parse();
    m_phase   = PH_LENGTH;
    m_remain  = '0;
    m_capture = 1'b0;
    m_done    = 1'b0;
    m_count   = '0;
    foreach (m_win[i]) m_win[i] = '0;
    m_hit     = 1'b0;
  endfunction

  // window slot 0 holds the newest name byte
  function automatic void push_name(logic [7:0] b);
    int n;
    bit ok;
    for (int i = TGT_MAX - 1; i > 0; i--) m_win[i] = m_win[i-1];
    m_win[0] = b;
    m_count++;
    n = (m_len > TGT_MAX) ? TGT_MAX : m_len;
    if (n == 0 || m_count < n) return;
    ok = 1'b1;
    for (int k = 0; k < n; k++)
      if (m_win[n-1-k] != tgt_byte(k)) ok = 1'b0;
    if (ok) m_hit = 1'b1;
  endfunction

  function automatic void parse_adv_byte(logic [7:0] b, logic fin);
    case (m_phase)
      PH_LENGTH: begin
        if (b != 8'h00) begin
          m_remain = b;
          m_phase  = PH_TYPE;
        end
      end
      PH_TYPE: begin
        m_remain = m_remain - 8'd1;
        if (b == alnf_pkg::NAME_TYPE && !m_done) begin
          m_done    = 1'b1;
          m_capture = 1'b1;
        end
        if (m_remain == 8'd0) begin
          m_capture = 1'b0;
          m_phase   = PH_LENGTH;
        end else begin
          m_phase = PH_VALUE;
        end
      end
      default: begin
        if (m_capture) begin
          if (b == 8'h00 || m_count >= NAME_CLAMP) m_capture = 1'b0;
          else push_name(b);
        end
        m_remain = m_remain - 8'd1;
        if (m_remain == 8'd0) begin
          m_capture = 1'b0;
          m_phase   = PH_LENGTH;
        end
      end
    endcase
    if (fin) begin
      name_reports.push_back('{m_done, m_count, m_hit});
      clear_parse();
    end
  endfunction

  function automatic void flag_bad(string what, name_report_t want, name_report_t got);
    n_bad++;
    if (n_bad <= 10)
      $display({"%0t mismatch (%s): expected found=%0d length=%0d match=%0d,",
                " got found=%0d length=%0d match=%0d"},
               $time, what, want.found, want.length, want.hit, got.found, got.length, got.hit);
  endfunction

  function automatic logic [63:0] rand64_nz();
    logic [63:0] v;
    for (int k = 0; k < 8; k++) v[8*k +: 8] = 8'($urandom_range(1, 255));
    return v;
  endfunction

  function automatic logic [7:0] rand_name_byte(int eff);
    if (eff > 0 && $urandom_range(0, 2) == 0) return tgt_byte($urandom_range(0, eff - 1));
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (!calm)
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid  <= 1'b1;
    adv_byte  <= b;
    last_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_adv_byte(b, fin);
    n_sent++;
  endtask

  task automatic send_adv();
    foreach (adv_q[i]) send_byte(adv_q[i], i == adv_q.size() - 1);
  endtask

  task automatic write_reg(input logic [alnf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      alnf_pkg::REG_TARGET_LOW:  m_lo  = val;
      alnf_pkg::REG_TARGET_HIGH: m_hi  = val;
      alnf_pkg::REG_TARGET_LEN:  m_len = val[4:0];
      default: ;
    endcase
  endtask

  task automatic write_target(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [63:0] len_word);
    write_reg(alnf_pkg::REG_TARGET_LOW, lo);
    write_reg(alnf_pkg::REG_TARGET_HIGH, hi);
    write_reg(alnf_pkg::REG_TARGET_LEN, len_word);
    cfg_write <= 1'b0;
  endtask

  // drain every report, then let trailing bytes clear the pipe
  task automatic settle();
    in_valid <= 1'b0;
    while (name_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_name_struct();
    logic [7:0] nm [$];
    int eff;
    int n;
    eff = (m_len > TGT_MAX) ? TGT_MAX : m_len;
    case ($urandom_range(0, 9))
      0: repeat ($urandom_range(30, 40)) nm.push_back(rand_name_byte(eff));
      1, 2, 3, 4: begin
        // target embedded, sometimes close to the clamp
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(18, 30) : $urandom_range(0, 4);
        repeat (n) nm.push_back(rand_name_byte(eff));
        for (int k = 0; k < eff; k++) nm.push_back(tgt_byte(k));
        repeat ($urandom_range(0, 4)) nm.push_back(rand_name_byte(eff));
      end
      default: repeat ($urandom_range(0, 12)) nm.push_back(rand_name_byte(eff));
    endcase
    if ($urandom_range(0, 7) == 0 && nm.size() > 0)
      nm[$urandom_range(0, nm.size() - 1)] = 8'h00;
    adv_q.push_back(8'(nm.size() + 1));
    adv_q.push_back(alnf_pkg::NAME_TYPE);
    foreach (nm[i]) adv_q.push_back(nm[i]);
  endtask

  task automatic build_adv(input bit broken);
    int vlen;
    int keep;
    adv_q.delete();
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 6))
        0, 1, 2: add_name_struct();
        3: adv_q.push_back(8'h00);
        default: begin
          vlen = $urandom_range(0, 6);
          adv_q.push_back(8'(vlen + 1));
          adv_q.push_back(8'($urandom_range(0, 255)));
          repeat (vlen) adv_q.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end
    if (broken) begin
      // cut the payload short and/or corrupt one byte
      if ($urandom_range(0, 1) == 1) begin
        keep = $urandom_range(1, adv_q.size());
        while (adv_q.size() > keep) void'(adv_q.pop_back());
      end
      if ($urandom_range(0, 1) == 1)
        adv_q[$urandom_range(0, adv_q.size() - 1)] = 8'($urandom_range(0, 255));
    end
  endtask

  task automatic random_target();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  n;
    lo = ($urandom_range(0, 2) == 0) ? {$urandom, $urandom} : rand64_nz();
    hi = ($urandom_range(0, 2) == 0) ? {$urandom, $urandom} : rand64_nz();
    case ($urandom_range(0, 9))
      0:       n = 5'd0;
      1:       n = 5'd16;
      2:       n = 5'($urandom_range(17, 31));
      3:       n = 5'd1;
      default: n = 5'($urandom_range(2, 15));
    endcase
    write_target(lo, hi, 64'(n));
  endtask

  task automatic test_directed();
    write_target({48'h0, 8'h42, 8'h41}, 64'h0, 64'd2);
    // zero length skipped, then a name with no value bytes
    adv_q = '{8'h00, 8'h01, alnf_pkg::NAME_TYPE};
    send_adv();
    // target inside the name; the second name structure is ignored
    adv_q = '{8'h04, alnf_pkg::NAME_TYPE, 8'h41, 8'h42, 8'h43,
              8'h03, alnf_pkg::NAME_TYPE, 8'h58, 8'h59};
    send_adv();
    // zero byte ends the capture
    adv_q = '{8'h05, alnf_pkg::NAME_TYPE, 8'h41, 8'h00, 8'h42, 8'h43};
    send_adv();
    // structure cut by the payload end
    adv_q = '{8'h08, alnf_pkg::NAME_TYPE, 8'h41, 8'h42};
    send_adv();
    adv_q = '{8'hFF};
    send_adv();
    settle();
  endtask

  task automatic test_target_settings();
    for (int s = 0; s < 6; s++) begin
      case (s)
        0: write_target(64'h0, 64'h0, 64'd0);
        1: write_target({8{8'hFF}}, {8{8'hFF}}, 64'd16);
        2: write_target(rand64_nz(), rand64_nz(), 64'd1);
        3: write_target(rand64_nz(), rand64_nz(), 64'd16);
        // upper data bits of the length register are don't-care
        4: write_target(rand64_nz(), rand64_nz(), {32'($urandom), 27'($urandom), 5'd31});
        default: write_target(rand64_nz(), rand64_nz(), 64'd17);
      endcase
      repeat (4) begin
        build_adv(1'b0);
        send_adv();
      end
      settle();
    end
  endtask

  task automatic test_target_change_midstream();
    write_target({48'h0, 8'h42, 8'h41}, 64'h0, 64'd2);
    // no final byte here, so no report yet
    adv_q = '{8'h08, alnf_pkg::NAME_TYPE, 8'h51, 8'h41};
    foreach (adv_q[i]) send_byte(adv_q[i], 1'b0);
    settle();
    write_target({48'h0, 8'h43, 8'h42}, 64'h0, 64'd2);
    adv_q = '{8'h42, 8'h43, 8'h44};
    send_adv();
    settle();
  endtask

  task automatic test_output_backpressure();
    calm     <= 1'b1;
    hold_req <= ~hold_req;
    // back-to-back last bytes pile up behind the held report
    repeat (40) begin
      if ($urandom_range(0, 3) == 0) build_adv(1'b0);
      else adv_q = '{8'($urandom_range(0, 255))};
      send_adv();
    end
    settle();
    calm <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_random();
    int next_cfg;
    int calm_from;
    int calm_to;
    int pick;
    next_cfg  = n_sent + 150;
    calm_from = n_sent + 100;
    calm_to   = calm_from + 200;
    while (n_sent < ITEM_GOAL) begin
      if (n_sent >= next_cfg) begin
        settle();
        random_target();
        next_cfg = n_sent + 150;
      end
      if (!calm && n_sent >= calm_from && n_sent < calm_to) calm <= 1'b1;
      else if (calm && n_sent >= calm_to) calm <= 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        build_adv(1'b0);
      end else if (pick < 90) begin
        build_adv(1'b1);
      end else begin
        adv_q.delete();
        repeat ($urandom_range(1, 8)) adv_q.push_back(8'($urandom_range(0, 255)));
      end
      send_adv();
    end
  endtask

  // output stall: random, quiet while calm, held during a hold-off request
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    name_report_t got;
    name_report_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{name_found, name_length, target_match};
      if (name_reports.size() == 0) begin
        flag_bad("no report pending", '0, got);
      end else begin
        want = name_reports.pop_front();
        if (got.found !== want.found || got.length !== want.length || got.hit !== want.hit)
          flag_bad("report", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no progress", $time);
      $display("adv_local_name_filter_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    m_lo  = '0;
    m_hi  = '0;
    m_len = '0;
    clear_parse();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_target_settings();
    test_target_change_midstream();
    test_output_backpressure();
    test_random();
    settle();
    if (name_reports.size() != 0) begin
      $display("%0d reports never arrived", name_reports.size());
      n_bad += name_reports.size();
    end
    if (n_bad == 0) begin
      $display("adv_local_name_filter_top regression: pass");
    end else begin
      $display("adv_local_name_filter_top regression: fail");
    end
    $finish;
  end

endmodule
